FILE: hdl/pvc_pkg.sv
// Shared types, constants and helpers of the per-server window controller.
`timescale 1ns / 1ps

package pvc_pkg;

    // Table geometry
    localparam int SERVER_COUNT = 16;
    localparam int SRV_IDX_W    = (SERVER_COUNT > 1) ? $clog2(SERVER_COUNT) : 1;

    // Field widths
    localparam int SERVER_W = 4;
    localparam int QLEN_W   = 16;
    localparam int FIX_W    = 32;
    localparam int CNT_W    = 16;
    localparam int EXT_W    = (SRV_IDX_W > SERVER_W) ? SRV_IDX_W : SERVER_W;

    // Stream word layout
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 1;
    localparam int RES_W      = SERVER_W + 2 * FIX_W + CNT_W;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - RES_W;

    // Configuration port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW  = 1'b1;

    // Event kinds
    localparam logic OP_DISPATCH = 1'b0;
    localparam logic OP_RESPONSE = 1'b1;

    // Q16.16 constants
    localparam logic [FIX_W-1:0] WINDOW_RESET = 32'd262144;
    localparam logic [FIX_W-1:0] STEP_DOWN    = 32'd13107;
    localparam logic [FIX_W-1:0] FLOOR_TEST   = 32'd65543;
    localparam logic [FIX_W-1:0] FLOOR_VALUE  = 32'd65602;
    localparam logic [FIX_W-1:0] HIGH_RESET   = 32'd131072;
    localparam logic [FIX_W-1:0] LOW_RESET    = 32'd65536;
    localparam logic [FIX_W-1:0] FIX_MAX      = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0] INFLIGHT_MAX = 16'hFFFF;

    // Divide-by-five accumulator, four quotient bits per cycle
    localparam int ACC_W       = 36;
    localparam int DIV5_DIGITS = ACC_W / 4;
    localparam int DIV5_CNT_W  = $clog2(DIV5_DIGITS + 1);

    // Serial divider for 2^32 / (5 * window)
    localparam int DIV_NUM_W = 33;
    localparam int DIV_DEN_W = 35;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Command queue
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Classified event handed from front to back
    typedef struct packed {
        logic                 resp;
        logic                 in_range;
        logic [SERVER_W-1:0]  server;
        logic [SRV_IDX_W-1:0] idx;
        logic [QLEN_W-1:0]    qlen;
    } t_cmd;

    // Result word, server in the lowest bits
    typedef struct packed {
        logic [CNT_W-1:0]    outstanding;
        logic [FIX_W-1:0]    smoothed;
        logic [FIX_W-1:0]    window;
        logic [SERVER_W-1:0] server;
    } t_result;

    // Threshold registers
    typedef struct packed {
        logic [FIX_W-1:0] high;
        logic [FIX_W-1:0] low;
    } t_cfg;

    // Four steps of long division by five: returns {remainder, quotient nibble}
    function automatic logic [6:0] div5_step(input logic [2:0] rem, input logic [3:0] bits);
        logic [3:0] r;
        logic [3:0] q;
        r = {1'b0, rem};
        q = '0;
        for (int k = 3; k >= 0; k--) begin
            r = {r[2:0], bits[k]};
            if (r >= 4'd5) begin
                r    = r - 4'd5;
                q[k] = 1'b1;
            end
        end
        return {r[2:0], q};
    endfunction

endpackage

FILE: hdl/per_server_window_controller.sv
// Top level: threshold registers, front stage, command queue and execution engine.
`timescale 1ns / 1ps

// Per-server congestion window controller.
// Input stream (s_axis): one word per event; tuser is the event kind
// (0 request dispatched, 1 response received), tdata carries the server
// index and the reported queue length. Output stream (m_axis): one word per
// event with the server index, its updated window, smoothed queue level and
// in-flight count. Config channel: index 0 writes the high threshold,
// index 1 the low threshold; always ready, write only while idle.
// Path: a word goes through the front register and the queue into the
// engine. A dispatch or an out-of-range server goes straight to the result
// register. A response first updates the average through the divide-by-five
// unit; a step down or a hold then writes the window, a shrink goes through
// that unit once more and the growth term through the serial divider. One
// event is worked at a time: the engine takes no new event until the result
// of the last one is loaded into the result register.
// Reset (synchronous, active low) sets every window to 4.0, averages and
// counts to zero and the thresholds to 2.0 and 1.0.
// A stalled receiver holds the result word; the engine waits with the next
// result, and the queue and front register keep taking up to three words.
module per_server_window_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Event input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: server[3:0], queue_len[19:4], zero pad[23:20]
    input  logic [pvc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: opcode[0]
    input  logic [pvc_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // Result output
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: server_out[3:0], window[35:4], smoothed_queue[67:36],
    //        outstanding[83:68], zero pad[87:84]
    output logic [pvc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration write
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pvc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pvc_pkg::FIX_W-1:0]      i_cfg_data
);
    import pvc_pkg::*;

    t_cfg    r_cfg;
    logic    push;
    logic    full;
    logic    cmd_valid;
    logic    pop;
    t_cmd    front_cmd;
    t_cmd    head_cmd;
    t_result result;

    // Threshold registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high <= HIGH_RESET;
            r_cfg.low  <= LOW_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HIGH: r_cfg.high <= i_cfg_data;
                REG_LOW:  r_cfg.low  <= i_cfg_data;
                default:  r_cfg      <= r_cfg;
            endcase
        end
    end

    pvc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser),
        .o_push  (push),
        .o_cmd   (front_cmd),
        .i_full  (full)
    );

    pvc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_data  (head_cmd)
    );

    pvc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .i_cfg       (r_cfg),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, result};

endmodule

FILE: hdl/pvc_div.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pvc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pvc_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [pvc_pkg::DIV_DEN_W-1:0] i_den,
    output logic                          o_done,
    output logic [pvc_pkg::DIV_NUM_W-1:0] o_quo
);
    import pvc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;
    logic [DIV_DEN_W-1:0] n_rem;

    // Trial subtract of the shifted remainder
    assign trial = {r_rem, r_num[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});
    assign n_rem = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_NUM_W);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[DIV_NUM_W-2:0], 1'b0};
                r_quo <= {r_quo[DIV_NUM_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: hdl/pvc_fifo.sv
// Short command queue between the front and the back.
`timescale 1ns / 1ps

module pvc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pvc_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pvc_pkg::t_cmd o_data
);
    import pvc_pkg::*;

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wptr;
    logic [FIFO_PTR_W-1:0] r_rptr;
    logic [FIFO_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rptr];

    function automatic logic [FIFO_PTR_W-1:0] wrap_inc(input logic [FIFO_PTR_W-1:0] p);
        return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wptr] <= i_data;
                r_wptr        <= wrap_inc(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= wrap_inc(r_rptr);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/pvc_front.sv
// Input stage: takes event words, classifies them and queues commands.
`timescale 1ns / 1ps

module pvc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [pvc_pkg::IN_DATA_W-1:0] i_data,
    input  logic [pvc_pkg::IN_USER_W-1:0] i_user,
    output logic                          o_push,
    output pvc_pkg::t_cmd                 o_cmd,
    input  logic                          i_full
);
    import pvc_pkg::*;

    logic                r_valid;
    t_cmd                r_cmd;
    t_cmd                n_cmd;
    logic [SERVER_W-1:0] server;
    logic [EXT_W-1:0]    srv_ext;

    // Unpack and classify the incoming word
    assign server  = i_data[SERVER_W-1:0];
    assign srv_ext = EXT_W'(server);

    always_comb begin
        n_cmd          = '0;
        n_cmd.resp     = (i_user[0] == OP_RESPONSE);
        n_cmd.in_range = (int'(server) < SERVER_COUNT);
        n_cmd.server   = server;
        n_cmd.idx      = srv_ext[SRV_IDX_W-1:0];
        n_cmd.qlen     = i_data[SERVER_W +: QLEN_W];
    end

    assign o_ready = !r_valid || !i_full;
    assign o_push  = r_valid && !i_full;
    assign o_cmd   = r_cmd;

    // One holding register in front of the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_valid <= 1'b1;
                r_cmd   <= n_cmd;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: hdl/pvc_back.sv
// Execution engine: per-server tables, average and window update, result register.
`timescale 1ns / 1ps

module pvc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  pvc_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    input  pvc_pkg::t_cfg    i_cfg,
    output logic             o_valid,
    input  logic             i_ready,
    output pvc_pkg::t_result o_result
);
    import pvc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV5,
        S_CLASS,
        S_WDIV,
        S_FLOOR,
        S_OUT
    } t_state;

    t_state r_state;

    // Per-server tables
    logic [FIX_W-1:0] r_win_tab [SERVER_COUNT];
    logic [FIX_W-1:0] r_avg_tab [SERVER_COUNT];
    logic [CNT_W-1:0] r_cnt_tab [SERVER_COUNT];

    // Working registers of the current event
    logic [SRV_IDX_W-1:0]  r_idx;
    logic [SERVER_W-1:0]   r_server;
    logic [FIX_W-1:0]      r_w;
    logic [FIX_W-1:0]      r_avg;
    logic [CNT_W-1:0]      r_cnt;
    logic [FIX_W-1:0]      r_nw;
    logic                  r_dec;
    logic [ACC_W-1:0]      r_acc;
    logic [ACC_W-1:0]      r_d5_quo;
    logic [2:0]            r_d5_rem;
    logic [DIV5_CNT_W-1:0] r_d5_cnt;
    t_result               r_res;
    logic                  r_out_valid;
    t_result               r_out;

    // Table read of the queued command
    logic [FIX_W-1:0] tab_w;
    logic [FIX_W-1:0] tab_avg;
    logic [CNT_W-1:0] tab_cnt;

    assign tab_w   = r_win_tab[i_cmd.idx];
    assign tab_avg = r_avg_tab[i_cmd.idx];
    assign tab_cnt = r_cnt_tab[i_cmd.idx];

    assign o_pop = (r_state == S_IDLE) && i_cmd_valid;

    // Result register load: empty or being drained this cycle
    logic out_load;

    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_ready);

    // Divide-by-five digit step
    logic [6:0]       d5;
    logic [ACC_W-1:0] n_d5_quo;

    assign d5       = div5_step(r_d5_rem, r_acc[ACC_W-1 -: 4]);
    assign n_d5_quo = {r_d5_quo[ACC_W-5:0], d5[3:0]};

    // Window classification
    logic                 is_high;
    logic                 is_low;
    logic                 may_dec;
    logic [DIV_DEN_W-1:0] w_x5;
    logic [FIX_W-1:0]     w_down;

    assign is_high = (r_avg > i_cfg.high);
    assign is_low  = (r_avg <= i_cfg.low);
    assign may_dec = ({r_cnt, 16'b0} <= r_w);
    assign w_x5    = {1'b0, r_w, 2'b00} + {3'b000, r_w};
    assign w_down  = (r_w >= STEP_DOWN) ? (r_w - STEP_DOWN) : '0;

    // Growth step 2^32 / (5 * W)
    logic                 div_start;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;
    logic [FIX_W:0]       grow_sum;

    assign div_start = (r_state == S_CLASS) && !is_high && is_low && (r_w != '0);
    assign grow_sum  = {1'b0, r_w} + div_quo;

    pvc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({1'b1, {(DIV_NUM_W - 1){1'b0}}}),
        .i_den   (w_x5),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Floor, count decrement and count increment
    logic [FIX_W-1:0] nw_floor;
    logic [CNT_W-1:0] cnt_dec;
    logic [CNT_W-1:0] cnt_inc;

    assign nw_floor = (r_nw < FLOOR_TEST) ? FLOOR_VALUE : r_nw;
    assign cnt_dec  = (r_cnt != '0) ? (r_cnt - 1'b1) : r_cnt;
    assign cnt_inc  = (tab_cnt < INFLIGHT_MAX) ? (tab_cnt + 1'b1) : tab_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < SERVER_COUNT; i++) begin
                r_win_tab[i] <= WINDOW_RESET;
                r_avg_tab[i] <= '0;
                r_cnt_tab[i] <= '0;
            end
        end else begin
            // Output register
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out       <= r_res;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_idx         <= i_cmd.idx;
                        r_server      <= i_cmd.server;
                        r_w           <= tab_w;
                        r_cnt         <= tab_cnt;
                        r_res.server  <= i_cmd.server;
                        if (!i_cmd.in_range) begin
                            r_res.window      <= '0;
                            r_res.smoothed    <= '0;
                            r_res.outstanding <= '0;
                            r_state           <= S_OUT;
                        end else if (!i_cmd.resp) begin
                            r_cnt_tab[i_cmd.idx] <= cnt_inc;
                            r_res.window         <= tab_w;
                            r_res.smoothed       <= tab_avg;
                            r_res.outstanding    <= cnt_inc;
                            r_state              <= S_OUT;
                        end else begin
                            // avg' = (4 * avg + q * 65536 + 2) / 5
                            r_acc    <= {2'b00, tab_avg, 2'b00}
                                        + {4'b0000, i_cmd.qlen, 16'b0} + ACC_W'(2);
                            r_d5_quo <= '0;
                            r_d5_rem <= '0;
                            r_d5_cnt <= DIV5_CNT_W'(DIV5_DIGITS);
                            r_dec    <= 1'b0;
                            r_state  <= S_DIV5;
                        end
                    end
                end

                S_DIV5: begin
                    r_acc    <= {r_acc[ACC_W-5:0], 4'b0000};
                    r_d5_quo <= n_d5_quo;
                    r_d5_rem <= d5[6:4];
                    r_d5_cnt <= r_d5_cnt - 1'b1;
                    if (r_d5_cnt == DIV5_CNT_W'(1)) begin
                        if (r_dec) begin
                            r_nw    <= n_d5_quo[FIX_W-1:0];
                            r_state <= S_FLOOR;
                        end else begin
                            r_avg   <= n_d5_quo[FIX_W-1:0];
                            r_state <= S_CLASS;
                        end
                    end
                end

                S_CLASS: begin
                    if (is_high) begin
                        if (may_dec) begin
                            // W' = (4 * W + 2) / 5
                            r_acc    <= {2'b00, r_w, 2'b00} + ACC_W'(2);
                            r_d5_quo <= '0;
                            r_d5_rem <= '0;
                            r_d5_cnt <= DIV5_CNT_W'(DIV5_DIGITS);
                            r_dec    <= 1'b1;
                            r_state  <= S_DIV5;
                        end else begin
                            r_nw    <= r_w;
                            r_state <= S_FLOOR;
                        end
                    end else if (is_low) begin
                        if (r_w == '0) begin
                            r_nw    <= FIX_MAX;
                            r_state <= S_FLOOR;
                        end else begin
                            r_state <= S_WDIV;
                        end
                    end else begin
                        r_nw    <= w_down;
                        r_state <= S_FLOOR;
                    end
                end

                S_WDIV: begin
                    if (div_done) begin
                        r_nw    <= grow_sum[FIX_W] ? FIX_MAX : grow_sum[FIX_W-1:0];
                        r_state <= S_FLOOR;
                    end
                end

                S_FLOOR: begin
                    r_win_tab[r_idx]  <= nw_floor;
                    r_avg_tab[r_idx]  <= r_avg;
                    r_cnt_tab[r_idx]  <= cnt_dec;
                    r_res.server      <= r_server;
                    r_res.window      <= nw_floor;
                    r_res.smoothed    <= r_avg;
                    r_res.outstanding <= cnt_dec;
                    r_state           <= S_OUT;
                end

                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: tb/tb_per_server_window_controller.sv
// Self-checking testbench of the per-server window controller: predicts each result word.
`timescale 1ns / 1ps

module tb_per_server_window_controller;

    import pvc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 36;
    localparam int SETTLE      = 60;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [FIX_W-1:0]      i_cfg_data    = '0;

    // Predicted per-server tables and thresholds
    logic [FIX_W-1:0] window_model   [SERVER_COUNT];
    logic [FIX_W-1:0] average_model  [SERVER_COUNT];
    logic [CNT_W-1:0] inflight_model [SERVER_COUNT];
    logic [FIX_W-1:0] high_thr;
    logic [FIX_W-1:0] low_thr;

    t_result pending_results[$];

    logic no_idle     = 1'b0;
    int   stall_left  = 0;
    int   cycle_count = 0;
    int   mismatch_count = 0;
    int   event_count    = 0;
    int   response_count = 0;
    int   reg_write_count = 0;
    int   word_count     = 0;

    per_server_window_controller u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, pending_results.size());
            $display("** per_server_window_controller: FAILED **");
            $finish;
        end
    end

    // Long receiver hold-off, counted down here
    always @(posedge i_clk) begin
        if (stall_left != 0) stall_left <= stall_left - 1;
    end

    // Receiver: random stalls unless held off or in a quiet stretch
    always @(posedge i_clk) begin
        m_axis_tready <= (stall_left == 0) &&
                         (no_idle || ($urandom_range(0, 99) >= IDLE_PCT));
    end

    // Window, average and count update of one event; returns the updated entry
    function automatic t_result apply_event(input logic op, input logic [SERVER_W-1:0] srv,
                                            input logic [QLEN_W-1:0] qlen);
        t_result          r;
        logic [63:0]      acc;
        logic [63:0]      quo;
        logic [63:0]      w64;
        logic [63:0]      nw;
        logic [63:0]      cnt64;
        logic [FIX_W-1:0] avg;
        logic [CNT_W-1:0] cnt;
        r.server = srv;
        r.window = '0;
        r.smoothed = '0;
        r.outstanding = '0;
        if (srv >= SERVER_COUNT) return r;
        cnt = inflight_model[srv];
        if (op == OP_DISPATCH) begin
            if (cnt != INFLIGHT_MAX) inflight_model[srv] = cnt + 1'b1;
        end else begin
            // average weights 0.8 / 0.2, rounded half up
            acc = {32'd0, average_model[srv]};
            acc = acc * 4 + ({48'd0, qlen} << 16) + 2;
            quo = acc / 5;
            avg = quo[FIX_W-1:0];
            average_model[srv] = avg;
            w64 = {32'd0, window_model[srv]};
            cnt64 = {48'd0, cnt};
            if (avg > high_thr) begin
                // shrink only while in-flight count fits in the window
                nw = ((cnt64 << 16) <= w64) ? (w64 * 4 + 2) / 5 : w64;
            end else if (avg <= low_thr) begin
                if (w64 == 0) begin
                    nw = {32'd0, FIX_MAX};
                end else begin
                    nw = w64 + (64'h1_0000_0000 / (w64 * 5));
                    if (nw > {32'd0, FIX_MAX}) nw = {32'd0, FIX_MAX};
                end
            end else begin
                nw = (w64 >= STEP_DOWN) ? w64 - STEP_DOWN : 64'd0;
            end
            if (nw < FLOOR_TEST) nw = {32'd0, FLOOR_VALUE};
            window_model[srv] = nw[FIX_W-1:0];
            if (cnt != 0) inflight_model[srv] = cnt - 1'b1;
        end
        r.window      = window_model[srv];
        r.smoothed    = average_model[srv];
        r.outstanding = inflight_model[srv];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [FIX_W-1:0] got,
                                   input logic [FIX_W-1:0] want);
        $display("MISMATCH word %0d %s: got 0x%08h expected 0x%08h",
                 word_count, what, got, want);
        mismatch_count++;
    endtask

    // Result checker: the word is taken at the next rising edge
    always @(negedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[RES_W-1:0];
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word, server", got.server, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.server != want.server)
                    report_mismatch("server", got.server, want.server);
                if (got.window != want.window)
                    report_mismatch("window", got.window, want.window);
                if (got.smoothed != want.smoothed)
                    report_mismatch("smoothed_queue", got.smoothed, want.smoothed);
                if (got.outstanding != want.outstanding)
                    report_mismatch("outstanding", got.outstanding, want.outstanding);
            end
            word_count++;
        end
    end

    // Offer one event word; returns at the edge it is taken
    task automatic send_event(input logic op, input logic [SERVER_W-1:0] srv,
                              input logic [QLEN_W-1:0] qlen);
        t_result expected;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_DATA_W - SERVER_W - QLEN_W){1'b0}}, qlen, srv};
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        expected = apply_event(op, srv, qlen);
        pending_results.insert(pending_results.size(), expected);
        event_count++;
        if (op == OP_RESPONSE) response_count++;
    endtask

    // Stop offering and wait until every predicted word has come back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [FIX_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        if (idx == REG_HIGH) high_thr = data;
        else low_thr = data;
        reg_write_count++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Field extremes on both event kinds
    task automatic test_field_extremes();
        send_event(OP_DISPATCH, 4'd0, 16'hFFFF);
        send_event(OP_DISPATCH, 4'd15, 16'h0000);
        send_event(OP_DISPATCH, 4'd10, 16'h5555);
        send_event(OP_DISPATCH, 4'd5, 16'hAAAA);
        send_event(OP_RESPONSE, 4'd15, 16'hFFFF);
        send_event(OP_RESPONSE, 4'd0, 16'h0000);
        send_event(OP_RESPONSE, 4'd10, 16'hAAAA);
    endtask

    // Growth, step down, shrink, hold when over-committed, and the floor
    task automatic test_window_regions();
        send_event(OP_RESPONSE, 4'd1, 16'd1);
        send_event(OP_RESPONSE, 4'd1, 16'd3);
        send_event(OP_RESPONSE, 4'd1, 16'd3);
        send_event(OP_RESPONSE, 4'd1, 16'd20);
        send_event(OP_RESPONSE, 4'd1, 16'd20);
        repeat (5) send_event(OP_DISPATCH, 4'd2, 16'd0);
        send_event(OP_RESPONSE, 4'd2, 16'd100);
        repeat (7) send_event(OP_RESPONSE, 4'd3, 16'd60000);
    endtask

    // Receiver stalls long enough for the input side to back up
    task automatic test_output_stall();
        wait_idle();
        stall_left <= 400;
        for (int i = 0; i < 12; i++)
            send_event(i[0] ? OP_RESPONSE : OP_DISPATCH, i[3:0], 16'(i));
        wait_idle();
    endtask

    // Random traffic under one threshold setting
    task automatic test_random_traffic(input logic [FIX_W-1:0] hi, input logic [FIX_W-1:0] lo,
                                       input int n_events, input logic quiet);
        logic                op;
        logic [SERVER_W-1:0] srv;
        logic [QLEN_W-1:0]   qlen;
        int                  pick;
        wait_idle();
        write_register(REG_HIGH, hi);
        write_register(REG_LOW, lo);
        no_idle <= quiet;
        for (int i = 0; i < n_events; i++) begin
            op  = ($urandom_range(0, 99) < 50) ? OP_RESPONSE : OP_DISPATCH;
            srv = ($urandom_range(0, 1) == 0) ? SERVER_W'($urandom_range(0, 3))
                                              : SERVER_W'($urandom_range(0, 15));
            pick = $urandom_range(0, 99);
            // mostly small levels so the average hovers around the thresholds
            if (pick < 60) qlen = QLEN_W'($urandom_range(0, 3));
            else if (pick < 85) qlen = QLEN_W'($urandom_range(0, 40));
            else qlen = QLEN_W'($urandom);
            send_event(op, srv, qlen);
        end
        wait_idle();
        no_idle <= 1'b0;
    endtask

    initial begin
        logic [FIX_W-1:0] rand_hi;
        for (int i = 0; i < SERVER_COUNT; i++) begin
            window_model[i]   = WINDOW_RESET;
            average_model[i]  = '0;
            inflight_model[i] = '0;
        end
        high_thr = HIGH_RESET;
        low_thr  = LOW_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_window_regions();
        test_output_stall();

        test_random_traffic(HIGH_RESET, LOW_RESET, 310, 1'b0);
        test_random_traffic('0, '0, 250, 1'b0);
        test_random_traffic(FIX_MAX, FIX_MAX, 250, 1'b1);
        test_random_traffic(FIX_MAX, '0, 250, 1'b0);
        // crossed: low above high, the high test wins
        test_random_traffic(32'd65536, 32'd196608, 250, 1'b0);
        rand_hi = $urandom_range(65536, 6 * 65536);
        test_random_traffic(rand_hi, $urandom_range(0, rand_hi), 250, 1'b0);

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);

        $display("Covered %0d events (%0d responses) in %0d cycles, %0d threshold writes,",
                 event_count, response_count, cycle_count, reg_write_count);
        $display("field extremes, all window regions and a long output stall; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("** per_server_window_controller: PASSED **");
        else
            $display("** per_server_window_controller: FAILED **");
        $finish;
    end

endmodule
